FILE: rtl/ifed_pkg.sv
// ----------------------------------------------------------------------------
// ifed_pkg: shared types and constants for the spin-flip energy delta core
// Action codes, register indexes, status codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package ifed_pkg;

   localparam int MAX_SPINS_DEF     = 64;
   localparam int MAX_COUPLINGS_DEF = 256;
   localparam int DIAG_DEPTH_DEF    = 1024;

   localparam int VAL_W   = 32;
   localparam int DELTA_W = 48;
   localparam int ACC_W   = 64;

   typedef enum logic [2:0] {
      ACT_WR_FIELD = 3'd0,
      ACT_WR_COUP  = 3'd1,
      ACT_WR_DIAG  = 3'd2,
      ACT_WR_SPIN  = 3'd3,
      ACT_EV_ONE   = 3'd4,
      ACT_EV_PAIR  = 3'd5
   } action_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_SAME  = 2'd2;

   localparam logic [1:0] REG_SPIN_COUNT = 2'd0;
   localparam logic [1:0] REG_COUP_COUNT = 2'd1;
   localparam logic [1:0] REG_DIAG_SIZE  = 2'd2;
   localparam logic [1:0] REG_WEIGHT     = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic clear;      // clearing pass over the field RAM
      logic load;       // capture item and clear accumulator
      logic do_write;   // perform store write for a write action
      logic fields;     // add first field term, read second field
      logic field2;     // add second field term on a pair
      logic coup_rd;    // issue coupling read at walk index
      logic coup_acc;   // accumulate the returned coupling
      logic idx;        // compute pattern indices
      logic diag_rd0;   // read diag[before]
      logic diag_rd1;   // read diag[after]
      logic diag_mul;   // form difference diag[after] - diag[before]
      logic diag_acc;   // multiply weight by difference
      logic finish;     // add rounded product, saturate and register result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic is_write;
      logic is_eval;
      logic err;
      logic walk_last;
   } sts_type;

endpackage

FILE: rtl/ifed_ram.sv
// ----------------------------------------------------------------------------
// ifed_ram: generic single-port RAM
// One address per cycle; a write also reads the old word; registered read data.
// ----------------------------------------------------------------------------
module ifed_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

FILE: rtl/ifed_datapath.sv
// ----------------------------------------------------------------------------
// ifed_datapath: stores and arithmetic for the energy delta core
// Spin register, field, coupling and diagonal RAMs, accumulator.
// ----------------------------------------------------------------------------
module ifed_datapath #(
   parameter int MAX_SPINS     = 64,
   parameter int MAX_COUPLINGS = 256,
   parameter int DIAG_DEPTH    = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ifed_pkg::cmd_type     cmd,
   output ifed_pkg::sts_type     sts,
   input  logic [2:0]            req_action,
   input  logic [9:0]            req_slot,
   input  logic [5:0]            req_first_spin,
   input  logic [5:0]            req_second_spin,
   input  logic signed [31:0]    req_value,
   input  logic                  req_spin_down,
   input  logic [6:0]            cfg_spin_count,
   input  logic [8:0]            cfg_coupling_count,
   input  logic [10:0]           cfg_diag_size,
   input  logic signed [31:0]    cfg_weight,
   output logic signed [47:0]    res_delta,
   output logic [1:0]            res_status,
   output logic                  res_used
);
   import ifed_pkg::*;

   localparam int SW = $clog2(MAX_SPINS);
   localparam int CW = $clog2(MAX_COUPLINGS) > 0 ? $clog2(MAX_COUPLINGS) : 1;
   localparam int DW = $clog2(DIAG_DEPTH);
   localparam int CNW = $clog2(MAX_COUPLINGS + 1);
   localparam int CE_W = VAL_W + 12;

   // captured item
   logic [2:0]        act_ff;
   logic [9:0]        slot_ff;
   logic [5:0]        s1_ff, s2_ff;
   logic signed [31:0] val_ff;
   logic              down_ff;
   logic              err_ff;
   logic [1:0]        stat_ff;

   logic [MAX_SPINS-1:0] spin_ff;
   logic [SW-1:0]        clr_ff;

   logic signed [ACC_W-1:0] acc_ff;
   logic [CNW-1:0]          walk_ff;
   logic                    walk_v_ff;
   logic [63:0]             before_ff, after_ff;
   logic                    dok_ff;
   logic signed [31:0]      dbef_ff;
   logic signed [32:0]      diff_ff;
   logic signed [64:0]      prod_ff;
   logic signed [47:0]      delta_ff;
   logic                    used_ff;

   // spin bit of a coupling endpoint; beyond the store reads as +1
   function automatic logic spin_bit(input logic [5:0] s);
      if (32'(s) < MAX_SPINS) return spin_ff[s[SW-1:0]];
      return 1'b0;
   endfunction

   // effective counts
   logic [6:0]  n_spin;
   logic [CNW-1:0] n_coup;
   logic [16:0] n_diag;
   always_comb begin
      n_spin = (cfg_spin_count > 7'(MAX_SPINS)) ? 7'(MAX_SPINS) : cfg_spin_count;
      n_coup = (32'(cfg_coupling_count) > MAX_COUPLINGS) ? CNW'(MAX_COUPLINGS)
             : CNW'(cfg_coupling_count);
      n_diag = (32'(cfg_diag_size) > DIAG_DEPTH) ? 17'(DIAG_DEPTH) : 17'(cfg_diag_size);
   end

   // action decode on the incoming item
   logic in_write, in_eval, in_err;
   logic [1:0] in_stat;
   always_comb begin
      in_write = 1'b0;
      in_eval  = 1'b0;
      in_err   = 1'b0;
      in_stat  = ST_OK;
      unique case (req_action)
         ACT_WR_FIELD, ACT_WR_SPIN: begin
            in_write = 1'b1;
            in_err   = 32'(req_first_spin) >= MAX_SPINS;
         end
         ACT_WR_COUP: begin
            in_write = 1'b1;
            in_err   = 32'(req_slot) >= MAX_COUPLINGS;
         end
         ACT_WR_DIAG: begin
            in_write = 1'b1;
            in_err   = 32'(req_slot) >= DIAG_DEPTH;
         end
         ACT_EV_ONE: begin
            in_eval = 1'b1;
            in_err  = 7'(req_first_spin) >= n_spin;
         end
         ACT_EV_PAIR: begin
            in_eval = 1'b1;
            if (7'(req_first_spin) >= n_spin || 7'(req_second_spin) >= n_spin) begin
               in_err = 1'b1;
            end else if (req_first_spin == req_second_spin) begin
               in_err  = 1'b1;
               in_stat = ST_SAME;
            end
         end
         default: ;
      endcase
      if (in_err && in_stat == ST_OK) in_stat = ST_RANGE;
   end

   logic is_write_ff, is_eval_ff;
   logic pair;
   assign pair = (act_ff == ACT_EV_PAIR);

   // field RAM: cleared by a pass after reset, first spin read, then second
   logic           f_we;
   logic [SW-1:0]  f_addr;
   logic [31:0]    f_wdata;
   logic [31:0]    f_rd;
   assign f_we    = cmd.clear || (cmd.do_write && act_ff == ACT_WR_FIELD);
   assign f_wdata = cmd.clear ? 32'd0 : val_ff;
   always_comb begin
      if (cmd.clear) f_addr = clr_ff;
      else if (cmd.fields) f_addr = s2_ff[SW-1:0];
      else f_addr = s1_ff[SW-1:0];
   end

   ifed_ram #(.WIDTH(32), .DEPTH(MAX_SPINS)) u_field_ram (
      .clock(clock), .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rd));

   // coupling RAM: {strength, end_a, end_b}
   logic              c_we;
   logic [CW-1:0]     c_addr;
   logic [CE_W-1:0]   c_rd;
   assign c_we   = cmd.do_write && act_ff == ACT_WR_COUP;
   assign c_addr = c_we ? slot_ff[CW-1:0] : walk_ff[CW-1:0];

   ifed_ram #(.WIDTH(CE_W), .DEPTH(MAX_COUPLINGS)) u_coup_ram (
      .clock(clock), .we(c_we), .addr(c_addr),
      .wdata({val_ff, s1_ff, s2_ff}), .rdata(c_rd));

   // diagonal RAM
   logic           d_we;
   logic [DW-1:0]  d_addr;
   logic [31:0]    d_rd;
   assign d_we = cmd.do_write && act_ff == ACT_WR_DIAG;
   always_comb begin
      if (d_we) d_addr = slot_ff[DW-1:0];
      else if (cmd.diag_rd1) d_addr = after_ff[DW-1:0];
      else d_addr = before_ff[DW-1:0];
   end

   ifed_ram #(.WIDTH(32), .DEPTH(DIAG_DEPTH)) u_diag_ram (
      .clock(clock), .we(d_we), .addr(d_addr), .wdata(val_ff), .rdata(d_rd));

   // coupling term of the returned entry
   logic [5:0] ca, cb, other;
   logic       hit;
   logic signed [31:0] cs;
   logic       sf, so;
   logic signed [ACC_W-1:0] cterm;
   always_comb begin
      cs = c_rd[CE_W-1:12];
      ca = c_rd[11:6];
      cb = c_rd[5:0];
      hit = 1'b0;
      other = ca;
      if (ca != cb) begin
         if (ca == s1_ff) begin
            hit = 1'b1; other = cb;
            if (pair && cb == s2_ff) hit = 1'b0;
         end else if (ca == s2_ff && pair) begin
            hit = 1'b1; other = cb;
            if (cb == s1_ff) hit = 1'b0;
         end else if (cb == s1_ff) begin
            hit = 1'b1; other = ca;
            if (pair && ca == s2_ff) hit = 1'b0;
         end else if (cb == s2_ff && pair) begin
            hit = 1'b1; other = ca;
         end
      end
      // the flipped spin is whichever endpoint was not chosen as other
      sf = (other == ca) ? spin_bit(cb) : spin_bit(ca);
      so = spin_bit(other);
      // -2*c*sf*so: sign flips negate
      cterm = (sf ^ so) ? (ACC_W'(cs) <<< 1) : -(ACC_W'(cs) <<< 1);
   end

   // field term -2*f*s of the field word returned this cycle
   logic signed [ACC_W-1:0] fterm;
   logic                    fspin;
   always_comb begin
      fspin = cmd.field2 ? spin_ff[s2_ff[SW-1:0]] : spin_ff[s1_ff[SW-1:0]];
      fterm = ACC_W'(signed'(f_rd)) <<< 1;
      if (!fspin) fterm = -fterm;
   end

   // pattern index
   logic [63:0] bef;
   always_comb begin
      bef = '0;
      for (int j = 0; j < MAX_SPINS; j++) begin
         if (7'(j) < n_spin) bef[j] = spin_ff[j];
      end
   end

   logic signed [47:0] rnd;
   logic signed [ACC_W-1:0] sum;
   always_comb begin
      rnd = 48'((prod_ff + 65'sd32768) >>> 16);
      sum = acc_ff + (dok_ff ? ACC_W'(rnd) : ACC_W'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spin_ff   <= '0;
         walk_v_ff <= 1'b0;
         clr_ff    <= '0;
      end else begin
         if (cmd.do_write && !err_ff) begin
            if (act_ff == ACT_WR_SPIN)  spin_ff[s1_ff[SW-1:0]] <= down_ff;
         end
         if (cmd.clear) clr_ff <= clr_ff + 1'b1;
         walk_v_ff <= cmd.coup_rd;
      end
      if (cmd.load) begin
         act_ff      <= req_action;
         slot_ff     <= req_slot;
         s1_ff       <= req_first_spin;
         s2_ff       <= req_second_spin;
         val_ff      <= req_value;
         down_ff     <= req_spin_down;
         err_ff      <= in_err;
         stat_ff     <= in_stat;
         is_write_ff <= in_write;
         is_eval_ff  <= in_eval;
         acc_ff      <= '0;
         walk_ff     <= '0;
         used_ff     <= 1'b0;
      end
      if (cmd.fields) acc_ff <= acc_ff + fterm;
      if (cmd.field2 && pair) acc_ff <= acc_ff + fterm;
      if (cmd.coup_rd) walk_ff <= walk_ff + 1'b1;
      if (cmd.coup_acc && walk_v_ff && hit) acc_ff <= acc_ff + cterm;
      if (cmd.idx) begin
         before_ff <= bef;
         after_ff  <= bef ^ (64'(1) << s1_ff) ^ (pair ? (64'(1) << s2_ff) : 64'(0));
         dok_ff    <= 1'b0;
      end
      if (cmd.diag_rd0) begin
         dok_ff <= n_diag != 0 && before_ff < 64'(n_diag) && after_ff < 64'(n_diag);
      end
      if (cmd.diag_rd1) dbef_ff <= d_rd;
      if (cmd.diag_mul) begin
         diff_ff <= 33'(signed'(d_rd)) - 33'(dbef_ff);
      end
      if (cmd.diag_acc) prod_ff <= 65'(cfg_weight) * 65'(diff_ff);
      if (cmd.finish) begin
         if (!is_eval_ff || err_ff) begin
            delta_ff <= '0;
            used_ff  <= 1'b0;
         end else begin
            if (sum > ACC_W'(48'sh7FFF_FFFF_FFFF)) delta_ff <= 48'sh7FFF_FFFF_FFFF;
            else if (sum < -ACC_W'(48'sh7FFF_FFFF_FFFF) - 1) delta_ff <= 48'sh8000_0000_0000;
            else delta_ff <= sum[47:0];
            used_ff <= dok_ff;
         end
      end
   end

   assign res_delta  = delta_ff;
   assign res_status = (is_eval_ff || is_write_ff) ? stat_ff : ST_OK;
   assign res_used   = used_ff;

   assign sts.clear_last = (clr_ff == SW'(MAX_SPINS - 1));
   assign sts.is_write   = is_write_ff;
   assign sts.is_eval    = is_eval_ff;
   assign sts.err        = err_ff;
   assign sts.walk_last  = walk_ff >= n_coup;
endmodule

FILE: rtl/ifed_ctrl.sv
// ----------------------------------------------------------------------------
// ifed_ctrl: sequencer for the energy delta core
// Accepts an item, steps the datapath, holds the result register valid.
// ----------------------------------------------------------------------------
module ifed_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ifed_pkg::cmd_type cmd,
   input  ifed_pkg::sts_type sts
);
   import ifed_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_FIELD, S_FIELD2, S_WALK, S_DRAIN, S_IDX, S_D0,
      S_D1, S_DMUL, S_DPROD, S_FIN, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: if (req_valid) begin
            cmd.load = 1'b1;
            state_in = S_DECODE;
         end
         S_DECODE: begin
            if (sts.is_write && !sts.err) cmd.do_write = 1'b1;
            state_in = (sts.is_eval && !sts.err) ? S_FIELD : S_FIN;
         end
         S_FIELD: begin
            cmd.fields = 1'b1;
            state_in   = S_FIELD2;
         end
         S_FIELD2: begin
            cmd.field2 = 1'b1;
            state_in   = S_WALK;
         end
         S_WALK: begin
            cmd.coup_acc = 1'b1;
            if (sts.walk_last) state_in = S_DRAIN;
            else cmd.coup_rd = 1'b1;
         end
         S_DRAIN: begin
            cmd.coup_acc = 1'b1;
            state_in     = S_IDX;
         end
         S_IDX: begin
            cmd.idx  = 1'b1;
            state_in = S_D0;
         end
         S_D0: begin
            cmd.diag_rd0 = 1'b1;
            state_in     = S_D1;
         end
         S_D1: begin
            cmd.diag_rd1 = 1'b1;
            state_in     = S_DMUL;
         end
         S_DMUL: begin
            cmd.diag_mul = 1'b1;
            state_in     = S_DPROD;
         end
         S_DPROD: begin
            cmd.diag_acc = 1'b1;
            state_in     = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= (state_in == S_OUT);
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = valid_ff;
endmodule

FILE: rtl/ising_flip_energy_delta_core.sv
// ----------------------------------------------------------------------------
// ising_flip_energy_delta_core: spin-flip energy change evaluator
// Loads spins, fields, couplings and a constraint diagonal; evaluates the
// Q16.16 energy change of flipping one spin or a pair of spins.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  req     | req_valid/ready, action..spin_down       | in
//  rsp     | rsp_valid/ready, delta_energy, status... | out
//  csr     | csr_psel/penable/pwrite/paddr/pwdata     | in (APB-style)
//
// Writes: the item is decoded and written in S_DECODE, its result is registered
// in S_FIN and held in S_OUT. An evaluation reads both field words, then walks
// every in-use coupling entry through the coupling RAM's single read port, one a
// cycle, then adds the diagonal term and registers the result.
// Reset: synchronous, spins +1; the field RAM is then zeroed by a clearing
// pass over all MAX_SPINS entries with req_ready low. Coupling and diagonal RAM
// contents undefined until written.
// One item in flight; req_ready is low until its result has been taken.
// ----------------------------------------------------------------------------
module ising_flip_energy_delta_core #(
   parameter int MAX_SPINS     = ifed_pkg::MAX_SPINS_DEF,
   parameter int MAX_COUPLINGS = ifed_pkg::MAX_COUPLINGS_DEF,
   parameter int DIAG_DEPTH    = ifed_pkg::DIAG_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_action,
   input  logic [9:0]         req_slot,
   input  logic [5:0]         req_first_spin,
   input  logic [5:0]         req_second_spin,
   input  logic signed [31:0] req_value,
   input  logic               req_spin_down,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [47:0] rsp_delta_energy,
   output logic [1:0]         rsp_status,
   output logic               rsp_constraint_used,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import ifed_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // configuration registers
   logic [6:0]         spin_count_ff;
   logic [8:0]         coup_count_ff;
   logic [10:0]        diag_size_ff;
   logic signed [31:0] weight_ff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         spin_count_ff <= 7'd64;
         coup_count_ff <= '0;
         diag_size_ff  <= '0;
         weight_ff     <= '0;
      end else if (csr_wr && csr_paddr[1:0] == 2'b00) begin
         unique case (csr_paddr[3:2])
            REG_SPIN_COUNT: spin_count_ff <= csr_pwdata[6:0];
            REG_COUP_COUNT: coup_count_ff <= csr_pwdata[8:0];
            REG_DIAG_SIZE:  diag_size_ff  <= csr_pwdata[10:0];
            REG_WEIGHT:     weight_ff     <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_SPIN_COUNT: csr_prdata = 32'(spin_count_ff);
         REG_COUP_COUNT: csr_prdata = 32'(coup_count_ff);
         REG_DIAG_SIZE:  csr_prdata = 32'(diag_size_ff);
         REG_WEIGHT:     csr_prdata = weight_ff;
         default:        csr_prdata = '0;
      endcase
   end

   ifed_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .cmd(cmd), .sts(sts));

   ifed_datapath #(
      .MAX_SPINS(MAX_SPINS), .MAX_COUPLINGS(MAX_COUPLINGS), .DIAG_DEPTH(DIAG_DEPTH)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_action(req_action), .req_slot(req_slot),
      .req_first_spin(req_first_spin), .req_second_spin(req_second_spin),
      .req_value(req_value), .req_spin_down(req_spin_down),
      .cfg_spin_count(spin_count_ff), .cfg_coupling_count(coup_count_ff),
      .cfg_diag_size(diag_size_ff), .cfg_weight(weight_ff),
      .res_delta(rsp_delta_energy), .res_status(rsp_status),
      .res_used(rsp_constraint_used));

   // never ready for a new item while a result is held
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");

   // constraint term only on ok evaluations
   a_used_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_constraint_used |-> rsp_status == ST_OK)
      else $error("constraint term on failed item");

   // accepted item yields no result next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid) else $error("result too early");
endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the spin-flip energy delta core
// Drives store writes and single/pair flip evaluations over several register
// settings and handshake idling patterns; a built-in predictor of the energy
// change checks every result item in order.
// ----------------------------------------------------------------------------
module tb_top;
   import ifed_pkg::*;

   // spare action codes that the block must treat as no-ops
   localparam logic [2:0] ACT_SPARE_LO = 3'd6;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;

   localparam int  IDLE_LIMIT = 20000;   // cycles with no item moving on either side
   localparam longint SAT_HI  = 64'sd140737488355327;
   localparam longint SAT_LO  = -64'sd140737488355328;

   typedef struct {
      logic signed [47:0] delta;
      logic [1:0]         status;
      logic               used;
   } energy_result_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_action = '0;
   logic [9:0]         req_slot = '0;
   logic [5:0]         req_first_spin = '0;
   logic [5:0]         req_second_spin = '0;
   logic signed [31:0] req_value = '0;
   logic               req_spin_down = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [47:0] rsp_delta_energy;
   logic [1:0]         rsp_status;
   logic               rsp_constraint_used;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [3:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   ising_flip_energy_delta_core DUT (.*);

   // ---------------------------------------------------------------------------
   // Clock and run-wide bookkeeping
   // ---------------------------------------------------------------------------
   initial begin
      forever #5 clock = ~clock;
   end

   energy_result_t expected_q[$];
   int  fail_count   = 0;
   int  items_sent   = 0;
   int  results_seen = 0;
   int  evals_sent   = 0;
   int  diag_hits    = 0;
   int  send_idle_pct = 0;   // chance per cycle that the sender holds back
   int  rcv_stall_pct = 0;   // chance per cycle that the receiver stalls
   int  rcv_hold      = 0;   // forced receiver stall, counted down per cycle

   // ---------------------------------------------------------------------------
   // Predictor state: a mirror of the block's stores and registers
   // ---------------------------------------------------------------------------
   logic [63:0]        spin_down_m;            // bit set = spin -1
   logic signed [31:0] field_m [64];
   logic signed [31:0] bond_strength_m [256];
   logic [5:0]         bond_end_a_m [256];
   logic [5:0]         bond_end_b_m [256];
   logic               bond_written [256];
   logic signed [31:0] diag_m [1024];
   logic               diag_written [1024];
   logic [6:0]         spin_count_r;
   logic [8:0]         bond_count_r;
   logic [10:0]        diag_size_r;
   logic signed [31:0] weight_r;

   function automatic int live_spins();
      return (spin_count_r > 64) ? 64 : int'(spin_count_r);
   endfunction

   function automatic int live_bonds();
      return (bond_count_r > 256) ? 256 : int'(bond_count_r);
   endfunction

   function automatic int live_diag();
      return (diag_size_r > 1024) ? 1024 : int'(diag_size_r);
   endfunction

   function automatic longint spin_sign(input int s);
      return spin_down_m[s] ? -64'sd1 : 64'sd1;
   endfunction

   // walk every in-use bond touching flipped spin f; optionally ignore the bond to skip
   function automatic longint bond_sum(input int f, input int skip, input bit use_skip);
      longint acc;
      int     other;
      acc = 0;
      for (int c = 0; c < live_bonds(); c++) begin
         if (bond_end_a_m[c] == bond_end_b_m[c]) continue;     // self bond adds nothing
         if (bond_end_a_m[c] == f) other = bond_end_b_m[c];
         else if (bond_end_b_m[c] == f) other = bond_end_a_m[c];
         else continue;
         if (use_skip && other == skip) continue;             // pair's own bond
         acc += -64'sd2 * longint'(bond_strength_m[c]) * spin_sign(f) * spin_sign(other);
      end
      return acc;
   endfunction

   function automatic logic [63:0] pattern_before();
      logic [63:0] mask;
      mask = (live_spins() == 64) ? '1 : ((64'd1 << live_spins()) - 64'd1);
      return spin_down_m & mask;
   endfunction

   function automatic logic [63:0] pattern_after(input int s1, input int s2, input bit pair);
      logic [63:0] idx;
      idx = pattern_before() ^ (64'd1 << s1);
      if (pair) idx ^= (64'd1 << s2);
      return idx;
   endfunction

   function automatic bit diag_term_on(input logic [63:0] b, input logic [63:0] a);
      return live_diag() > 0 && b < live_diag() && a < live_diag();
   endfunction

   // apply one accepted item to the mirror and queue the energy change it must give
   task automatic predict_energy(input logic [2:0] act, input logic [9:0] slot,
                                 input logic [5:0] s1, input logic [5:0] s2,
                                 input logic signed [31:0] val, input logic down);
      energy_result_t r;
      logic [63:0]    pb, pa;
      longint         d, prod;
      bit             pair;
      r = '{delta: '0, status: ST_OK, used: 1'b0};
      pair = (act == ACT_EV_PAIR);
      case (act)
         ACT_WR_FIELD: field_m[s1] = val;
         ACT_WR_SPIN:  spin_down_m[s1] = down;
         ACT_WR_COUP: begin
            if (slot >= 256) r.status = ST_RANGE;
            else begin
               bond_strength_m[slot] = val;
               bond_end_a_m[slot] = s1;
               bond_end_b_m[slot] = s2;
               bond_written[slot] = 1'b1;
            end
         end
         ACT_WR_DIAG: begin
            diag_m[slot] = val;
            diag_written[slot] = 1'b1;
         end
         ACT_EV_ONE, ACT_EV_PAIR: begin
            if (s1 >= live_spins() || (pair && s2 >= live_spins())) r.status = ST_RANGE;
            else if (pair && s1 == s2) r.status = ST_SAME;
            else begin
               d = -64'sd2 * longint'(field_m[s1]) * spin_sign(s1) + bond_sum(s1, s2, pair);
               if (pair)
                  d += -64'sd2 * longint'(field_m[s2]) * spin_sign(s2) + bond_sum(s2, s1, 1'b1);
               pb = pattern_before();
               pa = pattern_after(s1, s2, pair);
               if (diag_term_on(pb, pa)) begin
                  prod = longint'(weight_r) *
                         (longint'(diag_m[pa[9:0]]) - longint'(diag_m[pb[9:0]]));
                  d += (prod + 64'sd32768) >>> 16;   // round half up to Q16.16
                  r.used = 1'b1;
                  diag_hits++;
               end
               if (d > SAT_HI) d = SAT_HI;
               if (d < SAT_LO) d = SAT_LO;
               r.delta = d[47:0];
            end
         end
         default: ;   // spare codes: nothing changes, all-zero result
      endcase
      expected_q.push_back(r);
   endtask

   // ---------------------------------------------------------------------------
   // Result side: random stalls, forced hold-off, and in-order checking
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (rcv_hold > 0) begin
         rsp_ready <= 1'b0;
         rcv_hold  <= rcv_hold - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   int idle_cycles = 0;

   always @(posedge clock) begin
      energy_result_t e;
      if (reset) idle_cycles <= 0;
      else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;

      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result item: delta %0d status %0d used %0b",
                     $time, rsp_delta_energy, rsp_status, rsp_constraint_used);
            fail_count++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_delta_energy !== e.delta) begin
               $display("%0t: delta_energy expected %0d actual %0d",
                        $time, e.delta, rsp_delta_energy);
               fail_count++;
            end
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               fail_count++;
            end
            if (rsp_constraint_used !== e.used) begin
               $display("%0t: constraint_used expected %0b actual %0b",
                        $time, e.used, rsp_constraint_used);
               fail_count++;
            end
         end
      end
   end

   // watchdog: the block has stopped moving items
   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog expired, %0d result items outstanding",
                  $time, expected_q.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Item and register helpers
   // ---------------------------------------------------------------------------

   // offer one item (valid stays high between back-to-back items) and predict it
   task automatic send_item(input logic [2:0] act, input logic [9:0] slot,
                            input logic [5:0] s1, input logic [5:0] s2,
                            input logic signed [31:0] val, input logic down);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_action      = act;
      req_slot        = slot;
      req_first_spin  = s1;
      req_second_spin = s2;
      req_value       = val;
      req_spin_down   = down;
      req_valid       = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_energy(act, slot, s1, s2, val, down);
      items_sent++;
      if (act == ACT_EV_ONE || act == ACT_EV_PAIR) evals_sent++;
   endtask

   // sender pauses until every expected result item is back
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // APB write: setup then access; only called while the block is idle
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      @(negedge clock);
      req_valid   = 1'b0;
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = data;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      case (idx)
         REG_SPIN_COUNT: spin_count_r = data[6:0];
         REG_COUP_COUNT: bond_count_r = data[8:0];
         REG_DIAG_SIZE:  diag_size_r  = data[10:0];
         default:        weight_r     = data;
      endcase
   endtask

   task automatic set_regs(input int spins, input int bonds, input int diag,
                           input logic [31:0] weight);
      wait_drained();
      csr_write(REG_SPIN_COUNT, spins);
      csr_write(REG_COUP_COUNT, bonds);
      csr_write(REG_DIAG_SIZE, diag);
      csr_write(REG_WEIGHT, weight);
   endtask

   // mix of extremes, full-range and small Q16.16 values
   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2, 3:    return $urandom;
         default: return $urandom_range(32'h7FFFF) - 32'h40000;
      endcase
   endfunction

   function automatic logic [5:0] pick_spin();
      if ($urandom_range(9) == 0) return $urandom_range(63);
      return $urandom_range(live_spins() - 1);
   endfunction

   // bond endpoints cluster on low spins so that walks find touching bonds
   function automatic logic [5:0] pick_end();
      if ($urandom_range(3) == 0) return $urandom_range(63);
      return $urandom_range(15);
   endfunction

   task automatic fill_diag(input logic [63:0] idx);
      if (!diag_written[idx[9:0]])
         send_item(ACT_WR_DIAG, idx[9:0], $urandom, $urandom, pick_value(), $urandom);
   endtask

   // evaluation; any diagonal entry it would read is written first
   task automatic send_eval(input bit pair, input logic [5:0] s1, input logic [5:0] s2);
      logic [63:0] pb, pa;
      if (s1 < live_spins() && (!pair || (s2 < live_spins() && s1 != s2))) begin
         pb = pattern_before();
         pa = pattern_after(s1, s2, pair);
         if (diag_term_on(pb, pa)) begin
            fill_diag(pb);
            fill_diag(pa);
         end
      end
      send_item(pair ? ACT_EV_PAIR : ACT_EV_ONE, $urandom, s1, s2, $urandom, $urandom);
   endtask

   task automatic send_random_item();
      logic [5:0] s1, s2;
      s1 = pick_spin();
      s2 = ($urandom_range(9) == 0) ? s1 : pick_spin();
      case ($urandom_range(11))
         0:       send_item(ACT_WR_FIELD, $urandom, s1, $urandom, pick_value(), $urandom);
         1, 2:    send_item(ACT_WR_SPIN, $urandom, s1, $urandom, $urandom, $urandom);
         3: begin
            // rewrite an in-use slot, or aim beyond the store now and then
            if ($urandom_range(7) == 0)
               send_item(ACT_WR_COUP, $urandom_range(1023, 256), pick_end(), pick_end(),
                         pick_value(), $urandom);
            else
               send_item(ACT_WR_COUP, $urandom_range(255), pick_end(), pick_end(),
                         pick_value(), $urandom);
         end
         4:       send_item(ACT_WR_DIAG, $urandom, $urandom, $urandom, pick_value(), $urandom);
         5:       send_item($urandom_range(1) ? ACT_SPARE_LO : ACT_SPARE_HI, $urandom,
                            $urandom, $urandom, $urandom, $urandom);
         6, 7, 8: send_eval(1'b0, s1, s2);
         default: send_eval(1'b1, s1, s2);
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // field extremes, all actions, range and same-spin errors, spare codes
   task automatic test_directed();
      send_item(ACT_WR_FIELD, '0, 6'd0, '0, 32'sh7FFF_FFFF, 1'b0);
      send_item(ACT_WR_FIELD, '1, 6'd63, '1, 32'sh8000_0000, 1'b1);
      send_item(ACT_WR_SPIN, '0, 6'd63, '0, '0, 1'b1);
      send_item(ACT_EV_ONE, '0, 6'd0, '0, '0, 1'b0);
      send_item(ACT_EV_ONE, '1, 6'd63, '1, '1, 1'b1);
      send_item(ACT_EV_PAIR, '0, 6'd0, 6'd63, '0, 1'b0);
      send_item(ACT_EV_PAIR, '0, 6'd5, 6'd5, '0, 1'b0);         // pair names one spin
      send_item(ACT_WR_COUP, 10'd256, 6'd1, 6'd2, 32'sd65536, 1'b0);  // slot beyond store
      send_item(ACT_WR_COUP, 10'd1023, 6'd63, 6'd63, '1, 1'b1);
      send_item(ACT_WR_DIAG, 10'd1023, '0, '0, 32'sh7FFF_FFFF, 1'b0);
      send_item(ACT_WR_DIAG, 10'd0, '1, '1, 32'sh8000_0000, 1'b1);
      send_item(ACT_SPARE_LO, '1, '1, '1, '1, 1'b1);
      send_item(ACT_SPARE_HI, '1, '1, '1, '1, 1'b1);
      send_item(ACT_WR_SPIN, '1, 6'd63, '1, '1, 1'b0);
      set_regs(2, 0, 0, 0);
      send_item(ACT_EV_ONE, '0, 6'd5, '0, '0, 1'b0);            // spin beyond count
      send_item(ACT_EV_PAIR, '0, 6'd1, 6'd63, '0, 1'b0);        // second beyond count
      send_item(ACT_EV_PAIR, '0, 6'd40, 6'd40, '0, 1'b0);       // range wins over same spin
      send_item(ACT_EV_PAIR, '0, 6'd0, 6'd1, '0, 1'b0);
   endtask

   // every coupling slot gets content so any count reads written entries
   task automatic test_load_bonds();
      for (int c = 0; c < 256; c++)
         send_item(ACT_WR_COUP, c, pick_end(), ($urandom_range(15) == 0) ? 6'd3 : pick_end(),
                   pick_value(), $urandom);
   endtask

   task automatic test_random_phase(input int n, input int spins, input int bonds,
                                    input int diag, input logic [31:0] weight,
                                    input int idle_pct, input int stall_pct);
      set_regs(spins, bonds, diag, weight);
      send_idle_pct = idle_pct;
      rcv_stall_pct = stall_pct;
      for (int i = 0; i < n; i++) send_random_item();
      send_idle_pct = 0;
      rcv_stall_pct = 0;
   endtask

   // receiver holds off while items keep coming; the input side must stall
   task automatic test_backpressure();
      set_regs(6, 12, 64, 32'h0001_8000);
      rcv_hold = 400;
      for (int i = 0; i < 8; i++) send_random_item();
      wait_drained();
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      spin_down_m = '0;
      for (int i = 0; i < 64; i++) field_m[i] = '0;
      for (int i = 0; i < 256; i++) bond_written[i] = 1'b0;
      for (int i = 0; i < 1024; i++) begin
         diag_written[i] = 1'b0;
         diag_m[i] = '0;
      end
      spin_count_r = 7'd64;
      bond_count_r = '0;
      diag_size_r  = '0;
      weight_r     = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_load_bonds();
      test_random_phase(80, 8, 32, 256, 32'h0001_0000, 0, 0);
      test_random_phase(80, 6, 64, 2047, 32'h8000_0000, 57, 0);
      test_random_phase(80, 64, 16, 1024, 32'h7FFF_FFFF, 0, 57);
      test_backpressure();
      test_random_phase(40, 127, 511, 0, 32'hFFFF_FFFF, 7, 7);     // full 256-bond walk
      test_random_phase(40, 1, 0, 1, $urandom, 57, 57);
      test_random_phase(80, 4, 8, 16, $urandom, 7, 7);
      test_random_phase(30, 10, 256, 1024, 32'hFFFE_0000, 0, 0);

      wait_drained();
      repeat (20) @(posedge clock);
      if (expected_q.size() != 0) begin
         $display("%0t: %0d expected result items never arrived", $time, expected_q.size());
         fail_count++;
      end
      $display("Run covered %0d items (%0d evaluations, %0d with diagonal term)",
               items_sent, evals_sent, diag_hits);
      $display("  over nine register settings; %0d results checked, %0d failures",
               results_seen, fail_count);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
